// File: design/tdp_pkg.sv
// tdp_pkg: types, constants and helper functions for the time-of-day literal parser
// no dependencies; imported by every design file of the block

package tdp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned FRAC_W  = 10;
    localparam int unsigned SEC_W   = 28;
    localparam int unsigned TIME_W  = 38;
    localparam int unsigned COUNT_W = 8;

    localparam logic [3:0] LONG_LEN = 4'd11;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_T_LO  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_T_UP  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_O_LO  = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_O_UP  = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_D_LO  = 8'h64;
    localparam logic [CHAR_W-1:0] CH_D_UP  = 8'h44;
    localparam logic [CHAR_W-1:0] CH_I_LO  = 8'h69;
    localparam logic [CHAR_W-1:0] CH_I_UP  = 8'h49;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;
    localparam logic [SEC_W-1:0]   SEC_PER_HOUR = 28'd3600;
    localparam logic [SEC_W-1:0]   SEC_PER_MIN  = 28'd60;
    localparam logic [TIME_W-1:0]  MS_PER_SEC   = 38'd1000;

    typedef enum logic [3:0] {
        PH_START,
        PH_T,
        PH_TO,
        PH_LONG,
        PH_HASH,
        PH_BODY,
        PH_HOURS,
        PH_MIN,
        PH_SEC,
        PH_FRAC,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic               status;
        logic [SEC_W-1:0]   seconds;
        logic [FRAC_W-1:0]  msec;
        logic [COUNT_W-1:0] count;
    } t_sum;

    // character of the long prefix at a position, lower or upper spelling
    function automatic logic [CHAR_W-1:0] long_char(input logic upper, input logic [3:0] idx);
        logic [CHAR_W-1:0] lo;
        unique case (idx)
            4'd0:    lo = 8'h74;
            4'd1:    lo = 8'h69;
            4'd2:    lo = 8'h6D;
            4'd3:    lo = 8'h65;
            4'd4:    lo = 8'h5F;
            4'd5:    lo = 8'h6F;
            4'd6:    lo = 8'h66;
            4'd7:    lo = 8'h5F;
            4'd8:    lo = 8'h64;
            4'd9:    lo = 8'h61;
            4'd10:   lo = 8'h79;
            default: lo = CH_NUL;
        endcase
        if (upper && lo != 8'h5F) begin
            return lo & 8'hDF;
        end
        return lo;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // decimal accumulate, saturating at the field maximum
    function automatic logic [FIELD_W-1:0] accum(input logic [FIELD_W-1:0] v,
                                                 input logic [3:0] d);
        logic [FIELD_W+3:0] n;
        n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d};
        return (n > {4'b0, FIELD_MAX}) ? FIELD_MAX : n[FIELD_W-1:0];
    endfunction

endpackage

// File: design/tdp_if.sv
// tdp_if: request channel interfaces (valid/ready) for characters and results
// depends on tdp_pkg

interface tdp_char_if
    import tdp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tdp_res_if
    import tdp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic [TIME_W-1:0]  time_ms;
    logic [COUNT_W-1:0] consumed_chars;

    modport source (output valid, output status, output time_ms, output consumed_chars,
                    input ready);
    modport sink   (input valid, input status, input time_ms, input consumed_chars,
                    output ready);
endinterface

// File: design/time_of_day_literal_parser.sv
// time_of_day_literal_parser: top level of the time-of-day literal parser
// depends on tdp_pkg, tdp_if, tdp_parser and tdp_scale
//
// characters come in on i_char, one per request, and a zero character ends a literal;
// optional prefix: tod in any case, or the long time-of-day word all lower or all upper,
// followed by #; then hh[:mm[:ss[.fff]]]
// exactly one request leaves on o_result per terminator: status, time_ms, consumed_chars;
// other characters give no result
// a terminator's result passes from the input register through the state machine into a sum
// register, then through the times-1000 multiply into the output register that drives o_result
// throughput: one character per cycle while no terminator waits for the sum register
// when o_result is stalled, results queue in the sum and output registers and the
// input register; characters other than terminators keep flowing, and a terminator
// waits in the input register until the sum register frees up
// synchronous reset clears all valids and returns the parser to the start of a literal

module time_of_day_literal_parser
    import tdp_pkg::*;
#(
    parameter int unsigned LENGTH_LIMIT = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdp_char_if.sink  i_char,
    tdp_res_if.source o_result
);

    logic sum_valid;
    logic sum_ready;
    t_sum sum;

    tdp_parser #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .o_sum_valid (sum_valid),
        .i_sum_ready (sum_ready),
        .o_sum       (sum)
    );

    tdp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_valid (sum_valid),
        .o_sum_ready (sum_ready),
        .i_sum       (sum),
        .o_result    (o_result)
    );

endmodule

// File: design/tdp_parser.sv
// tdp_parser: input register, literal state machine and seconds/fraction result register
// depends on tdp_pkg and tdp_if

module tdp_parser
    import tdp_pkg::*;
#(
    parameter int unsigned LENGTH_LIMIT = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdp_char_if.sink     i_char,
    output logic         o_sum_valid,
    input  logic         i_sum_ready,
    output t_sum         o_sum
);

    localparam int unsigned LIM_W = $clog2(LENGTH_LIMIT + 1);
    localparam int unsigned CW    = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
    localparam logic [CW-1:0] LIMIT = CW'(LENGTH_LIMIT);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_prefix_idx, n_prefix_idx;
    logic               r_upper, n_upper;
    logic [FIELD_W-1:0] r_hours, n_hours;
    logic [FIELD_W-1:0] r_minutes, n_minutes;
    logic [FIELD_W-1:0] r_seconds, n_seconds;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [1:0]         r_frac_digits, n_frac_digits;
    logic [CW-1:0]      r_count, n_count;
    logic               r_error, n_error;

    logic          r_sum_valid;
    t_sum          r_sum, n_sum;

    logic          sum_free;
    logic          is_term;
    logic          take;
    logic          ok;
    logic [3:0]    dig;
    logic [CW-1:0] count_inc;
    logic [13:0]   frac_next;

    assign sum_free  = !r_sum_valid || i_sum_ready;
    assign is_term   = (r_in_char == CH_NUL);
    assign take      = r_in_valid && (!is_term || sum_free);
    assign i_char.ready = !r_in_valid || take;
    assign dig       = r_in_char[3:0];
    assign count_inc = (r_count < LIMIT) ? r_count + 1'b1 : r_count;
    assign frac_next = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1) + {10'b0, dig};

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_prefix_idx  <= '0;
            r_upper       <= 1'b0;
            r_hours       <= '0;
            r_minutes     <= '0;
            r_seconds     <= '0;
            r_frac        <= '0;
            r_frac_digits <= '0;
            r_count       <= '0;
            r_error       <= 1'b0;
            r_sum_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_prefix_idx  <= n_prefix_idx;
            r_upper       <= n_upper;
            r_hours       <= n_hours;
            r_minutes     <= n_minutes;
            r_seconds     <= n_seconds;
            r_frac        <= n_frac;
            r_frac_digits <= n_frac_digits;
            r_count       <= n_count;
            r_error       <= n_error;
            if (take && is_term) begin
                r_sum_valid <= 1'b1;
            end else if (i_sum_ready) begin
                r_sum_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_term) begin
            r_sum <= n_sum;
        end
    end

    // literal state machine
    always_comb begin
        n_phase       = r_phase;
        n_prefix_idx  = r_prefix_idx;
        n_upper       = r_upper;
        n_hours       = r_hours;
        n_minutes     = r_minutes;
        n_seconds     = r_seconds;
        n_frac        = r_frac;
        n_frac_digits = r_frac_digits;
        n_count       = r_count;
        n_error       = r_error;

        ok = !r_error && (r_phase == PH_HOURS || r_phase == PH_MIN || r_phase == PH_SEC ||
                          r_phase == PH_FRAC || r_phase == PH_STOP);
        n_sum.status  = !ok;
        n_sum.seconds = '0;
        n_sum.msec    = '0;
        n_sum.count   = '0;
        if (ok) begin
            n_sum.seconds = {12'b0, r_hours} * SEC_PER_HOUR + {12'b0, r_minutes} * SEC_PER_MIN
                            + {12'b0, r_seconds};
            unique case (r_frac_digits)
                2'd0: n_sum.msec = '0;
                2'd1: n_sum.msec = FRAC_W'(r_frac * 7'd100);
                2'd2: n_sum.msec = FRAC_W'(r_frac * 4'd10);
                2'd3: n_sum.msec = r_frac;
            endcase
            n_sum.count = r_count[COUNT_W-1:0];
        end

        if (take) begin
            if (is_term) begin
                n_phase       = PH_START;
                n_prefix_idx  = '0;
                n_upper       = 1'b0;
                n_hours       = '0;
                n_minutes     = '0;
                n_seconds     = '0;
                n_frac        = '0;
                n_frac_digits = '0;
                n_count       = '0;
                n_error       = 1'b0;
            end else if (!r_error) begin
                unique case (r_phase)
                    PH_START: begin
                        if (r_in_char == CH_T_LO || r_in_char == CH_T_UP) begin
                            n_upper = (r_in_char == CH_T_UP);
                            n_count = count_inc;
                            n_phase = PH_T;
                        end else if (is_digit(r_in_char)) begin
                            n_hours = accum(r_hours, dig);
                            n_count = count_inc;
                            n_phase = PH_HOURS;
                        end else if (r_in_char == CH_COLON) begin
                            n_count = count_inc;
                            n_phase = PH_MIN;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_T: begin
                        if (r_in_char == CH_O_LO || r_in_char == CH_O_UP) begin
                            n_count = count_inc;
                            n_phase = PH_TO;
                        end else if (r_in_char == (r_upper ? CH_I_UP : CH_I_LO)) begin
                            n_count      = count_inc;
                            n_prefix_idx = 4'd2;
                            n_phase      = PH_LONG;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_TO: begin
                        if (r_in_char == CH_D_LO || r_in_char == CH_D_UP) begin
                            n_count = count_inc;
                            n_phase = PH_HASH;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_LONG: begin
                        if (r_prefix_idx < LONG_LEN &&
                            r_in_char == long_char(r_upper, r_prefix_idx)) begin
                            n_count      = count_inc;
                            n_prefix_idx = r_prefix_idx + 1'b1;
                            if (n_prefix_idx >= LONG_LEN) begin
                                n_phase = PH_HASH;
                            end
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_HASH: begin
                        if (r_in_char == CH_HASH) begin
                            n_count = count_inc;
                            n_phase = PH_BODY;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_BODY, PH_HOURS: begin
                        if (is_digit(r_in_char)) begin
                            n_hours = accum(r_hours, dig);
                            n_count = count_inc;
                            n_phase = PH_HOURS;
                        end else if (r_in_char == CH_COLON) begin
                            n_count = count_inc;
                            n_phase = PH_MIN;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    PH_MIN: begin
                        if (is_digit(r_in_char)) begin
                            n_minutes = accum(r_minutes, dig);
                            n_count   = count_inc;
                        end else if (r_in_char == CH_COLON) begin
                            n_count = count_inc;
                            n_phase = PH_SEC;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_SEC: begin
                        if (is_digit(r_in_char)) begin
                            n_seconds = accum(r_seconds, dig);
                            n_count   = count_inc;
                        end else if (r_in_char == CH_DOT) begin
                            n_count = count_inc;
                            n_phase = PH_FRAC;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit(r_in_char)) begin
                            if (r_frac_digits != 2'd3) begin
                                n_frac        = frac_next[FRAC_W-1:0];
                                n_frac_digits = r_frac_digits + 1'b1;
                            end
                            n_count = count_inc;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        n_phase = PH_STOP;
                    end
                    default: begin
                        n_error = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

// File: design/tdp_scale.sv
// tdp_scale: converts seconds plus milliseconds to a millisecond count, output register
// depends on tdp_pkg and tdp_if

module tdp_scale
    import tdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_sum_valid,
    output logic      o_sum_ready,
    input  t_sum      i_sum,
    tdp_res_if.source o_result
);

    logic               r_valid;
    logic               r_status;
    logic [TIME_W-1:0]  r_time;
    logic [COUNT_W-1:0] r_count;
    logic               load;

    assign o_sum_ready = !r_valid || o_result.ready;
    assign load        = i_sum_valid && o_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_sum_ready) begin
            r_valid <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_sum.status;
            r_time   <= {10'b0, i_sum.seconds} * MS_PER_SEC + {28'b0, i_sum.msec};
            r_count  <= i_sum.count;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.status         = r_status;
    assign o_result.time_ms        = r_time;
    assign o_result.consumed_chars = r_count;

endmodule

// File: design/tdp_checker.sv
// tdp_checker: port-level assertions for the time-of-day literal parser, bound to the top
// depends on tdp_pkg and time_of_day_literal_parser

module tdp_checker
    import tdp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic               i_res_status,
    input logic [TIME_W-1:0]  i_res_time,
    input logic [COUNT_W-1:0] i_res_count
);

    localparam logic [TIME_W-1:0] TIME_MAX = 38'd239923635999;

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status) &&
        $stable(i_res_time) && $stable(i_res_count))
        else $error("stalled result changed");

    // error results carry no time and no count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status |-> i_res_time == '0 && i_res_count == '0)
        else $error("error result with nonzero payload");

    // time never exceeds saturated hours, minutes and seconds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_time <= TIME_MAX)
        else $error("time out of range");

    // no result right after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind time_of_day_literal_parser tdp_checker u_tdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_status (o_result.status),
    .i_res_time   (o_result.time_ms),
    .i_res_count  (o_result.consumed_chars)
);

// File: test/tb_time_of_day_literal_parser.sv
// tb_time_of_day_literal_parser: self-checking bench for the time-of-day literal parser
// depends on tdp_pkg, tdp_if and the time_of_day_literal_parser design files
// streams directed and random literals with random stalls, predicts each result and checks it

module tb_time_of_day_literal_parser;
    import tdp_pkg::*;

    localparam int unsigned LENGTH_LIMIT = 255;
    localparam int          RANDOM_CHARS = 1400;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // long prefix word, lower-case spelling
    localparam byte unsigned LONG_CODES [11] = '{8'h74, 8'h69, 8'h6D, 8'h65, 8'h5F, 8'h6F,
                                                 8'h66, 8'h5F, 8'h64, 8'h61, 8'h79};

    typedef struct packed {
        logic               status;
        logic [TIME_W-1:0]  time_ms;
        logic [COUNT_W-1:0] count;
    } t_answer;

    class t_scoreboard;
        t_phase             phase;
        logic [3:0]         pfx_pos;
        logic               pfx_upper;
        logic [FIELD_W-1:0] hours;
        logic [FIELD_W-1:0] minutes;
        logic [FIELD_W-1:0] seconds;
        logic [FRAC_W-1:0]  frac;
        int unsigned        frac_len;
        int unsigned        n_chars;
        logic               bad;
        t_answer            answers_due[$];
        int                 errors;
        int                 n_checked;

        function new();
            restart();
            errors = 0;
            n_checked = 0;
        endfunction

        function void restart();
            phase = PH_START;
            pfx_pos = 4'd0;
            pfx_upper = 1'b0;
            hours = '0;
            minutes = '0;
            seconds = '0;
            frac = '0;
            frac_len = 0;
            n_chars = 0;
            bad = 1'b0;
        endfunction

        function logic decimal(logic [CHAR_W-1:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function logic [FIELD_W-1:0] push_digit(logic [FIELD_W-1:0] v, logic [CHAR_W-1:0] c);
            int unsigned n;
            n = 32'(v) * 10 + 32'(c - CH_ZERO);
            return (n > 32'(FIELD_MAX)) ? FIELD_MAX : n[FIELD_W-1:0];
        endfunction

        function void tick();
            if (n_chars < LENGTH_LIMIT) n_chars++;
        endfunction

        function void hours_or_colon(logic [CHAR_W-1:0] c);
            if (decimal(c)) begin
                hours = push_digit(hours, c);
                tick();
                phase = PH_HOURS;
            end else if (c == CH_COLON) begin
                tick();
                phase = PH_MIN;
            end else begin
                bad = 1'b1;
            end
        endfunction

        function void finish_literal();
            t_answer         a;
            longint unsigned ms;
            logic            ok;
            ok = !bad && (phase == PH_HOURS || phase == PH_MIN || phase == PH_SEC ||
                          phase == PH_FRAC || phase == PH_STOP);
            a = '0;
            if (ok) begin
                ms = longint'(frac);
                for (int d = int'(frac_len); d < 3; d++) ms = ms * 10;
                ms += (longint'(hours) * 3600 + longint'(minutes) * 60 + longint'(seconds))
                      * 1000;
                a.status = 1'b0;
                a.time_ms = ms[TIME_W-1:0];
                a.count = n_chars[COUNT_W-1:0];
            end else begin
                a.status = 1'b1;
            end
            answers_due.push_back(a);
            restart();
        endfunction

        // advance the parser state by one accepted character
        function void take_char(logic [CHAR_W-1:0] c);
            logic [CHAR_W-1:0] want;
            if (c == CH_NUL) begin
                finish_literal();
                return;
            end
            if (bad) return;
            want = (pfx_pos < LONG_LEN) ? LONG_CODES[pfx_pos] : CH_NUL;
            if (pfx_upper && want != 8'h5F) want = want & 8'hDF;
            case (phase)
                PH_START: begin
                    if (c == CH_T_LO || c == CH_T_UP) begin
                        pfx_upper = (c == CH_T_UP);
                        tick();
                        phase = PH_T;
                    end else begin
                        hours_or_colon(c);
                    end
                end
                PH_T: begin
                    if (c == CH_O_LO || c == CH_O_UP) begin
                        tick();
                        phase = PH_TO;
                    end else if (c == (pfx_upper ? CH_I_UP : CH_I_LO)) begin
                        tick();
                        pfx_pos = 4'd2;
                        phase = PH_LONG;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_TO: begin
                    if (c == CH_D_LO || c == CH_D_UP) begin
                        tick();
                        phase = PH_HASH;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_LONG: begin
                    if (pfx_pos < LONG_LEN && c == want) begin
                        tick();
                        pfx_pos++;
                        if (pfx_pos >= LONG_LEN) phase = PH_HASH;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_HASH: begin
                    if (c == CH_HASH) begin
                        tick();
                        phase = PH_BODY;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_BODY, PH_HOURS: hours_or_colon(c);
                PH_MIN: begin
                    if (decimal(c)) begin
                        minutes = push_digit(minutes, c);
                        tick();
                    end else if (c == CH_COLON) begin
                        tick();
                        phase = PH_SEC;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_SEC: begin
                    if (decimal(c)) begin
                        seconds = push_digit(seconds, c);
                        tick();
                    end else if (c == CH_DOT) begin
                        tick();
                        phase = PH_FRAC;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_FRAC: begin
                    if (decimal(c)) begin
                        if (frac_len < 3) begin
                            frac = FRAC_W'(frac * 10 + (c - CH_ZERO));
                            frac_len++;
                        end
                        tick();
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_STOP: ;
                default: bad = 1'b1;
            endcase
        endfunction

        task report(string what);
            $display("error: %s", what);
            errors++;
        endtask

        task check_answer(logic status, logic [TIME_W-1:0] t, logic [COUNT_W-1:0] cnt);
            t_answer want;
            if (answers_due.size() == 0) begin
                report($sformatf("unexpected result: status %0b time_ms %0d count %0d",
                                 status, t, cnt));
                return;
            end
            want = answers_due.pop_front();
            if (status !== want.status)
                report($sformatf("result %0d status got %0b want %0b", n_checked, status,
                                 want.status));
            if (t !== want.time_ms)
                report($sformatf("result %0d time_ms got %0d want %0d", n_checked, t,
                                 want.time_ms));
            if (cnt !== want.count)
                report($sformatf("result %0d consumed_chars got %0d want %0d", n_checked, cnt,
                                 want.count));
            n_checked++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycles = 0;
    int          sent_chars = 0;
    bit          burst_tx = 1'b0;
    bit          burst_rx = 1'b0;

    t_scoreboard sb = new();

    tdp_char_if char_bus();
    tdp_res_if  res_bus();

    time_of_day_literal_parser #(
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (res_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("time_of_day_literal_parser: mismatch");
            $finish;
        end
    end

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [7:0] any_case(logic [7:0] lo);
        return $urandom_range(0, 1) ? (lo & 8'hDF) : lo;
    endfunction

    // long prefix word in lower or upper spelling
    function automatic string long_word(bit upper);
        string        s;
        byte unsigned ch;
        s = "";
        foreach (LONG_CODES[i]) begin
            ch = LONG_CODES[i];
            if (upper && ch != 8'h5F) ch = ch & 8'hDF;
            s = $sformatf("%s%c", s, ch);
        end
        return s;
    endfunction

    function automatic string digit_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'(8'h30 + $urandom_range(0, 9)));
        return s;
    endfunction

    function automatic string noise_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
        return s;
    endfunction

    function automatic int field_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(3, 7);
        return $urandom_range(1, 2);
    endfunction

    function automatic string well_formed();
        string s;
        int    n_frac;
        case ($urandom_range(0, 5))
            0: s = $sformatf("%c%c%c#", any_case(CH_T_LO), any_case(CH_O_LO), any_case(CH_D_LO));
            1: s = {long_word(1'b0), "#"};
            2: s = {long_word(1'b1), "#"};
            default: s = "";
        endcase
        s = {s, digit_run(field_len())};
        if ($urandom_range(0, 3) != 0) begin
            s = {s, ":", digit_run(field_len())};
            if ($urandom_range(0, 3) != 0) begin
                s = {s, ":", digit_run(field_len())};
                if ($urandom_range(0, 2) != 0) begin
                    // rare long fraction can drive the count into saturation
                    n_frac = ($urandom_range(0, 99) == 0) ? $urandom_range(240, 270)
                                                          : $urandom_range(0, 5);
                    s = {s, ".", digit_run(n_frac)};
                end
            end
        end
        if ($urandom_range(0, 7) == 0) s = {s, noise_run($urandom_range(1, 4))};
        return s;
    endfunction

    function automatic string make_literal();
        string s;
        int    r;
        int    pos;
        r = $urandom_range(0, 9);
        if (r < 7) return well_formed();
        if (r < 9) begin
            s = well_formed();
            if (s.len() == 0) return s;
            pos = $urandom_range(0, s.len() - 1);
            if ($urandom_range(0, 1)) s[pos] = 8'($urandom_range(1, 255));
            else s = s.substr(0, pos);
            return s;
        end
        return noise_run($urandom_range(0, 10));
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = draw_gap(burst_tx);
        if (gap > 0) begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.char_code <= c;
        do @(posedge i_clk); while (!char_bus.ready);
        sb.take_char(c);
        sent_chars++;
    endtask

    task automatic send_literal(input string s);
        if ($urandom_range(0, 9) == 0) burst_tx = !burst_tx;
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NUL);
    endtask

    initial begin
        string zeros;
        string lo_word;
        string up_word;
        string directed[$];
        char_bus.valid <= 1'b0;
        char_bus.char_code <= CH_NUL;
        res_bus.ready <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        zeros = "";
        repeat (260) zeros = {zeros, "0"};
        lo_word = long_word(1'b0);
        up_word = long_word(1'b1);
        directed = '{"12:34:56.789", "0", "tod#0", "TOD#23:59:59.999", "tOd#1:2",
                     {lo_word, "#7:08"}, {up_word, "#00:00:00.5"},
                     {lo_word.substr(0, 7), up_word.substr(8, 10), "#1"},
                     {up_word.substr(0, 0), lo_word.substr(1, 10), "#1"},
                     "tox#1", "to", "t", "tod#", "", "tod1", "12a",
                     "12:30x99", "1:2:3z", "1:2:3.4q5", "1:2:3.45678", ":5", "::.",
                     "99999:99999:99999.999"};
        directed.push_back(zeros);
        directed.push_back({"tod#1:2:3.", zeros});
        foreach (directed[i]) send_literal(directed[i]);

        while (sent_chars < RANDOM_CHARS) send_literal(make_literal());
        char_bus.valid <= 1'b0;

        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("time_of_day_literal_parser: match");
        end else begin
            $display("time_of_day_literal_parser: mismatch");
        end
        $finish;
    end

    // result side: random back-pressure, check on every accepted request
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap(burst_rx);
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            sb.check_answer(res_bus.status, res_bus.time_ms, res_bus.consumed_chars);
            if ($urandom_range(0, 15) == 0) burst_rx = !burst_rx;
        end
    end

endmodule
